// File: hdl/ihex_pkg.sv
// shared types and constants for the intel hex record parser
package ihex_pkg;

	// address space of the target image, wrapped and then cut to 16 bits
	localparam int unsigned ADDR_BITS = 16;
	localparam logic [15:0] ADDR_MASK = (ADDR_BITS >= 16) ? 16'hFFFF :
		16'((32'd1 << ADDR_BITS) - 32'd1);

	localparam int unsigned POS_BITS = 10;
	localparam logic [POS_BITS-1:0] POS_MAX = '1;

	// line positions of the header fields
	localparam logic [POS_BITS-1:0] POS_COUNT_END = POS_BITS'(2);
	localparam logic [POS_BITS-1:0] POS_ADDR_END  = POS_BITS'(6);
	localparam logic [POS_BITS-1:0] POS_TYPE_HI   = POS_BITS'(7);
	localparam logic [POS_BITS-1:0] POS_TYPE_LO   = POS_BITS'(8);

	localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
	localparam logic [7:0] CHAR_COLON   = 8'h3A;

	localparam logic [7:0] REC_DATA = 8'h00;
	localparam logic [7:0] REC_EOF  = 8'h01;

	localparam logic KIND_DATA = 1'b0;
	localparam logic KIND_EOF  = 1'b1;

	typedef struct packed {
		logic       is_newline;
		logic       is_colon;
		logic       is_hex;
		logic [3:0] nibble;
	} char_class_t;

	typedef struct packed {
		logic        valid;
		logic        kind;
		logic [15:0] addr;
		logic [7:0]  data;
	} result_t;

endpackage

// File: hdl/intel_hex_record_parser_core.sv
// intel hex parser top level: input register, parser, result register
// an accepted character beat goes into the input register, and its result beat is registered in the result register
// throughput: one character per cycle while char_stall is low, set by the single pass parser between registers
// a result beat held by result_stall stalls input only when the waiting character has a result
// reset (arst_n low, asynchronous) clears both stage valids and all parser state
module intel_hex_record_parser_core import ihex_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        char_valid,
	output logic        char_stall,
	input  logic [7:0]  char_in,
	output logic        result_valid,
	input  logic        result_stall,
	output logic        kind,
	output logic [15:0] write_address,
	output logic [7:0]  write_data
);

	// input register stage
	logic [7:0]  char_s1;
	logic        valid_s1;

	char_class_t char_class;
	result_t     result;

	// result register
	logic        out_valid_q;
	logic        kind_q;
	logic [15:0] addr_q;
	logic [7:0]  data_q;

	logic        out_free;
	logic        consume;

	ihex_char_decode u_decode (
		.char_code  (char_s1),
		.char_class (char_class)
	);

	ihex_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (consume),
		.char_class (char_class),
		.result     (result)
	);

	// result slot is free when empty or being taken this cycle
	assign out_free = !out_valid_q || !result_stall;
	// a character with no result never needs the result slot
	assign consume = valid_s1 && (!result.valid || out_free);
	// input stage holds only when its character cannot move on
	assign char_stall = valid_s1 && !consume;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (char_valid && !char_stall) begin
			valid_s1 <= 1'b1;
		end else if (consume) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (char_valid && !char_stall) begin
			char_s1 <= char_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (consume && result.valid) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// payload only, no reset needed
	always_ff @(posedge clk) begin
		if (consume && result.valid) begin
			kind_q <= result.kind;
			addr_q <= result.addr;
			data_q <= result.data;
		end
	end

	assign result_valid  = out_valid_q;
	assign kind          = kind_q;
	assign write_address = addr_q;
	assign write_data    = data_q;

endmodule

// File: hdl/ihex_char_decode.sv
// character classifier: newline, colon and hex digit value
module ihex_char_decode import ihex_pkg::*; (
	input  logic [7:0]  char_code,
	output char_class_t char_class
);

	always_comb begin
		char_class            = '0;
		char_class.is_newline = (char_code == CHAR_NEWLINE);
		char_class.is_colon   = (char_code == CHAR_COLON);
		if (char_code >= 8'h30 && char_code <= 8'h39) begin
			char_class.is_hex = 1'b1;
			char_class.nibble = char_code[3:0];
		end else if ((char_code >= 8'h41 && char_code <= 8'h46) ||
			(char_code >= 8'h61 && char_code <= 8'h66)) begin
			// a..f and A..F share the low bits: 1..6 maps to 10..15
			char_class.is_hex = 1'b1;
			char_class.nibble = char_code[3:0] + 4'd9;
		end
	end

endmodule

// File: hdl/ihex_parser.sv
// record parser state and per character result
module ihex_parser import ihex_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        advance,
	input  char_class_t char_class,
	output result_t     result
);

	logic [POS_BITS-1:0] pos_q, pos_n;
	logic                skip_q, skip_n;
	logic [7:0]          count_q, count_n;
	logic [15:0]         addr_q, addr_n;
	logic [7:0]          type_q, type_n;
	logic [3:0]          hi_q, hi_n;
	logic [7:0]          idx_q, idx_n;
	logic                done_q, done_n;
	logic [7:0]          type_full;
	logic [7:0]          idx_inc;
	logic [15:0]         addr_sum;

	assign type_full = type_q | {4'h0, char_class.nibble};
	assign idx_inc   = idx_q + 8'd1;
	assign addr_sum  = addr_q + {8'h00, idx_q};

	always_comb begin
		pos_n   = pos_q;
		skip_n  = skip_q;
		count_n = count_q;
		addr_n  = addr_q;
		type_n  = type_q;
		hi_n    = hi_q;
		idx_n   = idx_q;
		done_n  = done_q;
		result  = '0;
		if (!done_q) begin
			if (char_class.is_newline) begin
				pos_n  = '0;
				skip_n = 1'b0;
				hi_n   = '0;
				idx_n  = '0;
			end else begin
				if (pos_q != POS_MAX) begin
					pos_n = pos_q + POS_BITS'(1);
				end
				if (!skip_q) begin
					if (pos_q == '0) begin
						skip_n  = !char_class.is_colon;
						count_n = '0;
						addr_n  = '0;
						type_n  = '0;
						idx_n   = '0;
					end else if (!char_class.is_hex) begin
						skip_n = 1'b1;
					end else if (pos_q <= POS_COUNT_END) begin
						count_n = {count_q[3:0], char_class.nibble};
					end else if (pos_q <= POS_ADDR_END) begin
						addr_n = {addr_q[11:0], char_class.nibble};
					end else if (pos_q == POS_TYPE_HI) begin
						type_n = {char_class.nibble, 4'h0};
					end else if (pos_q == POS_TYPE_LO) begin
						type_n = type_full;
						if (type_full == REC_EOF) begin
							done_n       = 1'b1;
							result.valid = 1'b1;
							result.kind  = KIND_EOF;
						end else if (type_full != REC_DATA || count_q == 8'h00) begin
							skip_n = 1'b1;
						end
					end else if (pos_q[0]) begin
						// odd position: first digit of a data byte
						hi_n = char_class.nibble;
					end else begin
						idx_n        = idx_inc;
						skip_n       = (idx_inc >= count_q);
						result.valid = 1'b1;
						result.kind  = KIND_DATA;
						result.addr  = addr_sum & ADDR_MASK;
						result.data  = {hi_q, char_class.nibble};
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			skip_q  <= 1'b0;
			count_q <= '0;
			addr_q  <= '0;
			type_q  <= '0;
			hi_q    <= '0;
			idx_q   <= '0;
			done_q  <= 1'b0;
		end else if (advance) begin
			pos_q   <= pos_n;
			skip_q  <= skip_n;
			count_q <= count_n;
			addr_q  <= addr_n;
			type_q  <= type_n;
			hi_q    <= hi_n;
			idx_q   <= idx_n;
			done_q  <= done_n;
		end
	end

endmodule

// File: hdl/ihex_checker.sv
// port level checks for the intel hex parser, bound to the top level
module ihex_checker import ihex_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        char_valid,
	input logic        char_stall,
	input logic [7:0]  char_in,
	input logic        result_valid,
	input logic        result_stall,
	input logic        kind,
	input logic [15:0] write_address,
	input logic [7:0]  write_data
);

	logic eof_seen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eof_seen_q <= 1'b0;
		end else if (result_valid && !result_stall && kind == KIND_EOF) begin
			eof_seen_q <= 1'b1;
		end
	end

	// a held result beat keeps its payload
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(kind) &&
		$stable(write_address) && $stable(write_data))
		else $error("held result beat changed");

	// end marker carries zero address and data
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && kind == KIND_EOF |-> write_address == 16'h0000 && write_data == 8'h00)
		else $error("end marker with non zero payload");

	// input stalls only behind a waiting result
	assert property (@(posedge clk) disable iff (!arst_n)
		char_stall |-> result_valid)
		else $error("input stalled with result slot empty");

	// nothing follows the end marker
	assert property (@(posedge clk) disable iff (!arst_n)
		eof_seen_q |-> !result_valid)
		else $error("result beat after end marker");

endmodule

bind intel_hex_record_parser_core ihex_checker u_ihex_checker (.*);
